// File: rtl/voxel_first_point_filter_assert.svh
// Assertion helpers for the voxel first-point filter.
`ifndef VOXEL_FIRST_POINT_FILTER_ASSERT_SVH
`define VOXEL_FIRST_POINT_FILTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define VFPF_ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("vfpf: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define VFPF_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("vfpf: next-cycle check failed");

`endif

// File: rtl/vfpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vfpf_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 4096;
  localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
  localparam int MAX_PROBES    = 16;
  localparam int PROBE_W       = $clog2(MAX_PROBES + 1);
  localparam int EPOCH_W       = 8;

  // field widths
  localparam int COORD_W  = 32;
  localparam int INT_W    = 16;
  localparam int INV_W    = 26;
  localparam int STRIDE_W = 16;
  localparam int IDX_W    = 21;
  localparam int KEY_W    = 3 * IDX_W;
  localparam int PROD_W   = COORD_W + INV_W + 1;
  localparam int FRAC_W   = 32;
  localparam int CFG_AW   = 2;

  // front-to-back queue, depth must be a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);

  localparam logic [COORD_W-1:0] HASH_GOLDEN = 32'h9e37_79b9;
  localparam logic [INV_W-1:0]   INV_MAX     = 26'd65536000;
  localparam logic [INV_W-1:0]   INV_RESET   = 26'd655360;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd4;

  typedef enum logic [CFG_AW-1:0] {
    REG_FILTER_MODE    = 2'd0,
    REG_INV_VOXEL_SIZE = 2'd1,
    REG_KEEP_EVERY     = 2'd2,
    REG_PASS_INTENSITY = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_PROBE,
    B_CHECK,
    B_EMIT
  } back_state_t;

  // one classified point on its way to the table
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [INT_W-1:0]   intensity;
    logic               lookup;
    logic               keep;
    logic               last;
    logic [KEY_W-1:0]   key;
    logic [TBL_AW-1:0]  slot;
  } vfpf_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } vfpf_qstat_t;

  // one round of the key hash
  function automatic logic [COORD_W-1:0] mix(input logic [COORD_W-1:0] h,
                                             input logic [COORD_W-1:0] k);
    return h ^ (k + HASH_GOLDEN + (h << 6) + (h >> 2));
  endfunction

  // floor of Q27.32 product, saturated to a 21-bit index
  function automatic logic [IDX_W-1:0] sat_index(input logic [PROD_W-1:0] p);
    logic [PROD_W-FRAC_W-1:0] q;
    q = p[PROD_W-1:FRAC_W];
    if (q[PROD_W-FRAC_W-1] && !(&q[PROD_W-FRAC_W-1:IDX_W-1])) begin
      return {1'b1, {(IDX_W-1){1'b0}}};
    end else if (!q[PROD_W-FRAC_W-1] && (|q[PROD_W-FRAC_W-1:IDX_W-1])) begin
      return {1'b0, {(IDX_W-1){1'b1}}};
    end
    return q[IDX_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] sext_idx(input logic [IDX_W-1:0] k);
    return {{(COORD_W-IDX_W){k[IDX_W-1]}}, k};
  endfunction

endpackage

`default_nettype wire

// File: rtl/vfpf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module vfpf_front import vfpf_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [COORD_W-1:0]  in_x,
  input  wire logic [COORD_W-1:0]  in_y,
  input  wire logic [COORD_W-1:0]  in_z,
  input  wire logic [INT_W-1:0]    in_intensity,
  input  wire logic                in_finite,
  input  wire logic                in_last,
  input  wire logic                filter_mode,
  input  wire logic [INV_W-1:0]    inv_voxel_size,
  input  wire logic [STRIDE_W-1:0] keep_every,
  input  wire logic                pass_intensity,
  input  wire logic                clearing,
  input  wire vfpf_qstat_t         qstat,
  output logic                     push,
  output vfpf_item_t               push_item
);

  logic                       advance;
  logic                       accept;
  logic [INV_W-1:0]           inv_eff;
  logic [STRIDE_W-1:0]        stride_n;
  logic [STRIDE_W:0]          phase_inc;
  logic [STRIDE_W-1:0]        stride_phase;

  // product stage
  logic                       p_v;
  logic signed [PROD_W-1:0]   px, py, pz;
  vfpf_item_t                 p_item;

  // index stage
  logic                       k_v;
  logic [IDX_W-1:0]           kx, ky, kz;
  logic [COORD_W-1:0]         h1;
  vfpf_item_t                 k_item;

  // second hash stage
  logic                       g_v;
  logic [COORD_W-1:0]         h2;
  logic [COORD_W-1:0]         h3;
  vfpf_item_t                 g_in;
  vfpf_item_t                 g_item;

  // whole pipeline moves together; no point is taken in while the table is swept
  assign advance  = !qstat.full;
  assign in_ready = advance && !clearing;
  assign accept   = in_valid && in_ready;

  always_comb begin
    inv_eff = inv_voxel_size;
    if (inv_voxel_size == '0) begin
      inv_eff = INV_W'(1);
    end else if (inv_voxel_size > INV_MAX) begin
      inv_eff = INV_MAX;
    end
  end

  assign stride_n  = (keep_every == '0) ? STRIDE_W'(1) : keep_every;
  assign phase_inc = {1'b0, stride_phase} + (STRIDE_W+1)'(1);

  // stride phase: in stride mode every point of the frame counts
  always_ff @(posedge clk) begin
    if (rst) begin
      stride_phase <= '0;
    end else if (accept) begin
      if (in_last) begin
        stride_phase <= '0;
      end else if (filter_mode) begin
        stride_phase <= (phase_inc >= {1'b0, stride_n}) ? '0 : phase_inc[STRIDE_W-1:0];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
      k_v <= 1'b0;
      g_v <= 1'b0;
    end else if (advance) begin
      p_v <= accept;
      k_v <= p_v;
      g_v <= k_v;
    end
  end

  // multiply by reciprocal voxel size, classify
  always_ff @(posedge clk) begin
    if (advance) begin
      px <= $signed(in_x) * $signed({1'b0, inv_eff});
      py <= $signed(in_y) * $signed({1'b0, inv_eff});
      pz <= $signed(in_z) * $signed({1'b0, inv_eff});
      p_item.x         <= in_x;
      p_item.y         <= in_y;
      p_item.z         <= in_z;
      p_item.intensity <= pass_intensity ? in_intensity : '0;
      p_item.lookup    <= !filter_mode && in_finite;
      p_item.keep      <= filter_mode && in_finite && (stride_phase == '0);
      p_item.last      <= in_last;
      p_item.key       <= '0;
      p_item.slot      <= '0;
    end
  end

  // floor and saturate, first hash round (h starts at zero)
  always_ff @(posedge clk) begin
    if (advance) begin
      kx     <= sat_index(px);
      ky     <= sat_index(py);
      kz     <= sat_index(pz);
      h1     <= sext_idx(sat_index(px)) + HASH_GOLDEN;
      k_item <= p_item;
    end
  end

  // key assembly
  always_comb begin
    g_in     = k_item;
    g_in.key = {kz, ky, kx};
  end

  // second hash round
  always_ff @(posedge clk) begin
    if (advance) begin
      h2     <= mix(h1, sext_idx(ky));
      g_item <= g_in;
    end
  end

  // last hash round feeds the queue directly
  assign h3 = mix(h2, sext_idx(g_item.key[KEY_W-1:2*IDX_W]));

  always_comb begin
    push_item      = g_item;
    push_item.slot = h3[TBL_AW-1:0];
  end

  assign push = g_v && advance;

endmodule

`default_nettype wire

// File: rtl/vfpf_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module vfpf_queue import vfpf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire vfpf_item_t push_item,
  input  wire logic       pop,
  output vfpf_item_t      head,
  output vfpf_qstat_t     qstat
);

  vfpf_item_t       slots [QUEUE_DEPTH];
  logic [QA_W-1:0]  wr_ptr;
  logic [QA_W-1:0]  rd_ptr;
  logic [QA_W:0]    count;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QA_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QA_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QA_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QA_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  assign head        = slots[rd_ptr];
  assign qstat.full  = (count == (QA_W+1)'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

endmodule

`default_nettype wire

// File: rtl/vfpf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module vfpf_back import vfpf_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire vfpf_qstat_t  qstat,
  input  wire vfpf_item_t   head,
  output logic              pop,
  output logic              clearing,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [COORD_W-1:0] out_x,
  output logic [COORD_W-1:0] out_y,
  output logic [COORD_W-1:0] out_z,
  output logic [INT_W-1:0]  out_intensity,
  output logic              out_has_point,
  output logic              out_frame_done,
  output logic              out_overflow
);

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [KEY_W-1:0]   key;
  } entry_t;

  entry_t              table_mem [TABLE_ENTRIES];
  entry_t              rd_data;

  back_state_t         state, state_next;
  vfpf_item_t          work;
  logic [PROBE_W-1:0]  probe, probe_next;
  logic                keep, keep_next;
  logic                over, over_next;
  logic [EPOCH_W-1:0]  epoch, epoch_next;
  logic [EPOCH_W-1:0]  epoch_inc;
  logic [TBL_AW-1:0]   clr_addr, clr_addr_next;

  logic                wr_en;
  logic [TBL_AW-1:0]   wr_addr;
  entry_t              wr_data;
  logic                rd_en;
  logic [TBL_AW-1:0]   rd_addr;
  logic                load_out;
  logic                leave;

  assign rd_addr   = work.slot + TBL_AW'(probe);
  assign epoch_inc = epoch + EPOCH_W'(1);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      probe    <= '0;
      keep     <= 1'b0;
      over     <= 1'b0;
      epoch    <= EPOCH_W'(1);
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      probe    <= probe_next;
      keep     <= keep_next;
      over     <= over_next;
      epoch    <= epoch_next;
      clr_addr <= clr_addr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      work <= head;
    end
  end

  // next state: sweep, fetch, probe loop, emit
  always_comb begin
    state_next    = state;
    probe_next    = probe;
    keep_next     = keep;
    over_next     = over;
    epoch_next    = epoch;
    clr_addr_next = clr_addr;
    pop           = 1'b0;
    clearing      = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = clr_addr;
    wr_data       = '0;
    rd_en         = 1'b0;
    load_out      = 1'b0;
    leave         = 1'b0;
    case (state)
      B_CLEAR: begin
        clearing      = 1'b1;
        wr_en         = 1'b1;
        clr_addr_next = clr_addr + TBL_AW'(1);
        if (clr_addr == TBL_AW'(TABLE_ENTRIES - 1)) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!qstat.empty) begin
          pop        = 1'b1;
          probe_next = '0;
          keep_next  = head.keep;
          over_next  = 1'b0;
          state_next = head.lookup ? B_PROBE : B_EMIT;
        end
      end
      B_PROBE: begin
        rd_en      = 1'b1;
        state_next = B_CHECK;
      end
      B_CHECK: begin
        if (rd_data.epoch != epoch) begin
          // free slot this frame: claim it
          wr_en         = 1'b1;
          wr_addr       = rd_addr;
          wr_data.epoch = epoch;
          wr_data.key   = work.key;
          keep_next     = 1'b1;
          state_next    = B_EMIT;
        end else if (rd_data.key == work.key) begin
          state_next = B_EMIT;
        end else if (probe == PROBE_W'(MAX_PROBES - 1)) begin
          keep_next  = 1'b1;
          over_next  = 1'b1;
          state_next = B_EMIT;
        end else begin
          probe_next = probe + PROBE_W'(1);
          state_next = B_PROBE;
        end
      end
      B_EMIT: begin
        if (!(keep || work.last)) begin
          leave = 1'b1;
        end else if (!out_valid || out_ready) begin
          load_out = 1'b1;
          leave    = 1'b1;
        end
        if (leave) begin
          state_next = B_IDLE;
          if (work.last) begin
            // new frame: bump the epoch; on wrap, sweep the table
            if (epoch_inc == '0) begin
              epoch_next = EPOCH_W'(1);
              state_next = B_CLEAR;
            end else begin
              epoch_next = epoch_inc;
            end
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // voxel table
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= table_mem[rd_addr];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_x          <= keep ? work.x : '0;
      out_y          <= keep ? work.y : '0;
      out_z          <= keep ? work.z : '0;
      out_intensity  <= keep ? work.intensity : '0;
      out_has_point  <= keep;
      out_overflow   <= over;
      out_frame_done <= work.last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/voxel_first_point_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// Voxel first-point filter. Points enter on s_axis, kept points and frame
// markers leave on m_axis, at most one result per point. The front end takes
// one point per cycle, unless the queue is full or the table is being swept,
// into a three-stage multiply/floor/hash pipeline and a four-item queue. The
// back end pulls one item at a time: stride-mode and non-finite points go
// from fetch straight to emit; a voxel lookup reads, then compares, for each
// of 1 to 16 probes of the 4096-entry key table. Frames are told apart by an
// 8-bit epoch stored with each key, so a frame end costs nothing; after reset
// and after every 255 frames a sweep rewrites every table entry and no point
// is accepted during it. Configuration writes are taken at any time.
`include "voxel_first_point_filter_assert.svh"

module voxel_first_point_filter import vfpf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  // input points
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [111:0]      s_axis_tdata,   // x_pos, y_pos, z_pos, intensity_in
  input  wire logic              s_axis_tuser,   // coords_finite
  input  wire logic              s_axis_tlast,   // frame_last
  // results
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [111:0]           m_axis_tdata,   // out_x, out_y, out_z, out_intensity
  output logic [1:0]             m_axis_tuser,   // has_point, table_overflow
  output logic                   m_axis_tlast,   // frame_done
  // configuration
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [INV_W-1:0]  cfg_wdata
);

  logic                filter_mode;
  logic [INV_W-1:0]    inv_voxel_size;
  logic [STRIDE_W-1:0] keep_every;
  logic                pass_intensity;

  logic                clearing;
  logic                q_push;
  logic                q_pop;
  vfpf_item_t          q_in;
  vfpf_item_t          q_head;
  vfpf_qstat_t         q_stat;

  logic [COORD_W-1:0]  o_x, o_y, o_z;
  logic [INT_W-1:0]    o_int;
  logic                o_has, o_over;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode    <= 1'b0;
      inv_voxel_size <= INV_RESET;
      keep_every     <= STRIDE_RESET;
      pass_intensity <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_FILTER_MODE:    filter_mode    <= cfg_wdata[0];
        REG_INV_VOXEL_SIZE: inv_voxel_size <= cfg_wdata;
        REG_KEEP_EVERY:     keep_every     <= cfg_wdata[STRIDE_W-1:0];
        REG_PASS_INTENSITY: pass_intensity <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  vfpf_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .in_x           (s_axis_tdata[31:0]),
    .in_y           (s_axis_tdata[63:32]),
    .in_z           (s_axis_tdata[95:64]),
    .in_intensity   (s_axis_tdata[111:96]),
    .in_finite      (s_axis_tuser),
    .in_last        (s_axis_tlast),
    .filter_mode    (filter_mode),
    .inv_voxel_size (inv_voxel_size),
    .keep_every     (keep_every),
    .pass_intensity (pass_intensity),
    .clearing       (clearing),
    .qstat          (q_stat),
    .push           (q_push),
    .push_item      (q_in)
  );

  vfpf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .qstat     (q_stat)
  );

  vfpf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .qstat          (q_stat),
    .head           (q_head),
    .pop            (q_pop),
    .clearing       (clearing),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_x          (o_x),
    .out_y          (o_y),
    .out_z          (o_z),
    .out_intensity  (o_int),
    .out_has_point  (o_has),
    .out_frame_done (m_axis_tlast),
    .out_overflow   (o_over)
  );

  assign m_axis_tdata = {o_int, o_z, o_y, o_x};
  assign m_axis_tuser = {o_over, o_has};

  // checks
  `VFPF_ASSERT_IMPL(a_no_push_full, clk, rst, q_push, !q_stat.full)
  `VFPF_ASSERT_IMPL(a_no_pop_empty, clk, rst, q_pop, !q_stat.empty)
  `VFPF_ASSERT_IMPL(a_over_has_point, clk, rst, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0])
  `VFPF_ASSERT_IMPL(a_empty_closes, clk, rst, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast)
  `VFPF_ASSERT_NEXT(a_pop_no_sweep, clk, rst, q_pop, !clearing)

endmodule

`default_nettype wire
